/* rtl/core/vfw_pkg.sv */
package vfw_pkg;

    // Field and register widths
    localparam int SPEED_W   = 16;
    localparam int COUNT_W   = 8;
    localparam int TRIPLET_W = 48;
    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int NUM_WHEELS  = 4;
    localparam int NUM_SENSORS = 3;

    // Report queue depth between detector front and frame serialiser
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TOLERANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TICKS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMM_TICKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEAD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE    = 3'd5;

    // Register reset values
    localparam logic [SPEED_W-1:0] SPEED_TOLERANCE_RST = 16'd20;
    localparam logic [COUNT_W-1:0] STALL_TICKS_RST     = 8'd50;
    localparam logic [COUNT_W-1:0] COMM_TICKS_RST      = 8'd2;
    localparam logic [COUNT_W-1:0] REPORT_TICKS_RST    = 8'd10;
    localparam logic [WORD_W-1:0]  FRAME_HEAD_RST      = 16'd0;
    localparam logic [WORD_W-1:0]  COMMAND_CODE_RST    = 16'd0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // Fault mask bit positions
    localparam int FAULT_LINK        = 0;
    localparam int FAULT_WHEEL_FIRST = 1;
    localparam int FAULT_SENSOR_FIRST = 5;

    // Frame layout
    localparam int FRAME_LEN = 11;
    localparam int FRAME_IDX_W = 4;
    localparam logic [BYTE_W-1:0] FRAME_LEN_BYTE  = 8'd11;
    localparam logic [BYTE_W-1:0] FRAME_TYPE_BYTE = 8'd2;
    localparam logic [BYTE_W-1:0] FRAME_PAD_BYTE  = 8'd0;

    localparam logic [FRAME_IDX_W-1:0] FB_HEAD_LO = 4'd0;
    localparam logic [FRAME_IDX_W-1:0] FB_HEAD_HI = 4'd1;
    localparam logic [FRAME_IDX_W-1:0] FB_LEN     = 4'd2;
    localparam logic [FRAME_IDX_W-1:0] FB_CMD_LO  = 4'd3;
    localparam logic [FRAME_IDX_W-1:0] FB_CMD_HI  = 4'd4;
    localparam logic [FRAME_IDX_W-1:0] FB_PAD_A   = 4'd5;
    localparam logic [FRAME_IDX_W-1:0] FB_TYPE    = 4'd6;
    localparam logic [FRAME_IDX_W-1:0] FB_MASK    = 4'd7;
    localparam logic [FRAME_IDX_W-1:0] FB_PAD_B   = 4'd8;
    localparam logic [FRAME_IDX_W-1:0] FB_SUM_LO  = 4'd9;
    localparam logic [FRAME_IDX_W-1:0] FB_SUM_HI  = 4'd10;

    // One pending fault report
    typedef struct packed {
        logic [BYTE_W-1:0] mask;
        logic [WORD_W-1:0] head;
        logic [WORD_W-1:0] command;
    } vfw_report_t;

    // Saturating increment for watchdog counters
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        r = (c == COUNT_MAX) ? c : c + 1'b1;
        return r;
    endfunction

endpackage

/* rtl/core/vfw_if.sv */
interface vfw_tick_if;
    logic                  valid;
    logic                  ready;
    logic                  rx_ok;
    logic signed [15:0]    aim_three;
    logic signed [15:0]    now_three;
    logic signed [15:0]    aim_four;
    logic signed [15:0]    now_four;
    logic signed [15:0]    aim_left;
    logic signed [15:0]    now_left;
    logic signed [15:0]    aim_right;
    logic signed [15:0]    now_right;
    logic [47:0]           gyro_xyz;
    logic [47:0]           accel_xyz;
    logic [47:0]           mag_xyz;

    modport source (
        output valid, rx_ok, aim_three, now_three, aim_four, now_four,
               aim_left, now_left, aim_right, now_right,
               gyro_xyz, accel_xyz, mag_xyz,
        input  ready
    );
    modport sink (
        input  valid, rx_ok, aim_three, now_three, aim_four, now_four,
               aim_left, now_left, aim_right, now_right,
               gyro_xyz, accel_xyz, mag_xyz,
        output ready
    );
endinterface

interface vfw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface vfw_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

/* rtl/core/vfw_front.sv */
module vfw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    vfw_tick_if.sink             tick,
    vfw_cfg_if.sink              cfg,
    input  logic                 queue_full,
    output logic                 push,
    output vfw_pkg::vfw_report_t push_report
);
    import vfw_pkg::*;

    // Configuration registers
    logic [SPEED_W-1:0] speed_tolerance_reg;
    logic [COUNT_W-1:0] stall_ticks_reg;
    logic [COUNT_W-1:0] comm_ticks_reg;
    logic [COUNT_W-1:0] report_ticks_reg;
    logic [WORD_W-1:0]  frame_head_reg;
    logic [WORD_W-1:0]  command_code_reg;

    // Detector state
    logic [BYTE_W-1:0]    fault_mask_reg,  fault_mask_next;
    logic [COUNT_W-1:0]   link_count_reg,  link_count_next;
    logic [COUNT_W-1:0]   report_timer_reg, report_timer_next;
    logic [COUNT_W-1:0]   wheel_count_reg  [NUM_WHEELS];
    logic [COUNT_W-1:0]   wheel_count_next [NUM_WHEELS];
    logic [COUNT_W-1:0]   sensor_count_reg  [NUM_SENSORS];
    logic [COUNT_W-1:0]   sensor_count_next [NUM_SENSORS];
    logic [TRIPLET_W-1:0] prev_triplet_reg  [NUM_SENSORS];

    logic signed [SPEED_W-1:0] aim [NUM_WHEELS];
    logic signed [SPEED_W-1:0] now [NUM_WHEELS];
    logic [TRIPLET_W-1:0]      triplet [NUM_SENSORS];
    logic signed [SPEED_W:0]   diff [NUM_WHEELS];
    logic [SPEED_W:0]          abs_err [NUM_WHEELS];
    logic                      wheel_active [NUM_WHEELS];
    logic                      sensor_active [NUM_SENSORS];
    logic                      fire;
    logic                      accept;

    assign cfg.ready  = 1'b1;
    assign tick.ready = !queue_full;
    assign accept     = tick.valid && tick.ready;

    // Lane views of the tick payload
    always_comb
    begin
        aim[0] = tick.aim_three;  now[0] = tick.now_three;
        aim[1] = tick.aim_four;   now[1] = tick.now_four;
        aim[2] = tick.aim_left;   now[2] = tick.now_left;
        aim[3] = tick.aim_right;  now[3] = tick.now_right;
        triplet[0] = tick.gyro_xyz;
        triplet[1] = tick.accel_xyz;
        triplet[2] = tick.mag_xyz;
    end

    // Detector update for one tick
    always_comb
    begin
        fault_mask_next   = fault_mask_reg;
        report_timer_next = sat_inc(report_timer_reg);
        link_count_next   = link_count_reg;

        // link watchdog
        if (tick.rx_ok)
        begin
            link_count_next = '0;
        end
        else if (link_count_reg > comm_ticks_reg)
        begin
            fault_mask_next[FAULT_LINK] = 1'b1;
        end
        else
        begin
            link_count_next = sat_inc(link_count_reg);
        end

        // wheel speed loops
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            diff[w]    = {aim[w][SPEED_W-1], aim[w]} - {now[w][SPEED_W-1], now[w]};
            abs_err[w] = diff[w][SPEED_W] ? (~diff[w] + 1'b1) : diff[w];
            wheel_active[w] = abs_err[w] > {1'b0, speed_tolerance_reg};
            if (wheel_active[w])
            begin
                wheel_count_next[w] = sat_inc(wheel_count_reg[w]);
            end
            else
            begin
                if (wheel_count_reg[w] > stall_ticks_reg)
                begin
                    fault_mask_next[FAULT_WHEEL_FIRST + w] = 1'b1;
                end
                wheel_count_next[w] = '0;
            end
        end

        // frozen sensor triplets
        for (int s = 0; s < NUM_SENSORS; s++)
        begin
            sensor_active[s] = triplet[s] == prev_triplet_reg[s];
            if (sensor_active[s])
            begin
                sensor_count_next[s] = sat_inc(sensor_count_reg[s]);
            end
            else
            begin
                if (sensor_count_reg[s] > stall_ticks_reg)
                begin
                    fault_mask_next[FAULT_SENSOR_FIRST + s] = 1'b1;
                end
                sensor_count_next[s] = '0;
            end
        end

        fire = (fault_mask_next != '0) && (report_timer_next > report_ticks_reg);
    end

    assign push                = accept && fire;
    assign push_report.mask    = fault_mask_next;
    assign push_report.head    = frame_head_reg;
    assign push_report.command = command_code_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_tolerance_reg <= SPEED_TOLERANCE_RST;
            stall_ticks_reg     <= STALL_TICKS_RST;
            comm_ticks_reg      <= COMM_TICKS_RST;
            report_ticks_reg    <= REPORT_TICKS_RST;
            frame_head_reg      <= FRAME_HEAD_RST;
            command_code_reg    <= COMMAND_CODE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_SPEED_TOLERANCE: speed_tolerance_reg <= cfg.data;
                CFG_STALL_TICKS:     stall_ticks_reg     <= cfg.data[COUNT_W-1:0];
                CFG_COMM_TICKS:      comm_ticks_reg      <= cfg.data[COUNT_W-1:0];
                CFG_REPORT_TICKS:    report_ticks_reg    <= cfg.data[COUNT_W-1:0];
                CFG_FRAME_HEAD:      frame_head_reg      <= cfg.data;
                CFG_COMMAND_CODE:    command_code_reg    <= cfg.data;
                default: ;
            endcase
        end
    end

    // Detector state advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_mask_reg   <= '0;
            link_count_reg   <= '0;
            report_timer_reg <= '0;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                wheel_count_reg[w] <= '0;
            end
            for (int s = 0; s < NUM_SENSORS; s++)
            begin
                sensor_count_reg[s] <= '0;
                prev_triplet_reg[s] <= '0;
            end
        end
        else if (accept)
        begin
            fault_mask_reg   <= fire ? '0 : fault_mask_next;
            report_timer_reg <= fire ? '0 : report_timer_next;
            link_count_reg   <= link_count_next;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                wheel_count_reg[w] <= wheel_count_next[w];
            end
            for (int s = 0; s < NUM_SENSORS; s++)
            begin
                sensor_count_reg[s] <= sensor_count_next[s];
                prev_triplet_reg[s] <= triplet[s];
            end
        end
    end

endmodule

/* rtl/core/vfw_queue.sv */
module vfw_queue #(
    parameter int QUEUE_DEPTH = vfw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  vfw_pkg::vfw_report_t push_report,
    output logic                 full,
    output logic                 pop_valid,
    input  logic                 pop,
    output vfw_pkg::vfw_report_t pop_report
);
    import vfw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    vfw_report_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_report = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Report storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_report;
        end
    end

endmodule

/* rtl/core/vfw_back.sv */
module vfw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop,
    input  vfw_pkg::vfw_report_t pop_report,
    vfw_frame_if.source          frame
);
    import vfw_pkg::*;

    localparam logic [FRAME_IDX_W-1:0] IDX_LAST = FRAME_IDX_W'(FRAME_LEN - 1);

    logic                   busy_reg;
    logic [FRAME_IDX_W-1:0] idx_reg;
    vfw_report_t            rep_reg;
    logic [WORD_W-1:0]      sum_reg;
    logic [WORD_W-1:0]      sum_next;
    logic                   out_fire;
    logic                   last_out;

    assign out_fire = frame.valid && frame.ready;
    assign last_out = idx_reg == IDX_LAST;
    assign pop      = pop_valid && (!busy_reg || (out_fire && last_out));

    // Checksum over the nine leading bytes of the incoming report
    always_comb
    begin
        sum_next = WORD_W'(pop_report.head[7:0]) + WORD_W'(pop_report.head[15:8])
                 + WORD_W'(FRAME_LEN_BYTE)
                 + WORD_W'(pop_report.command[7:0]) + WORD_W'(pop_report.command[15:8])
                 + WORD_W'(FRAME_PAD_BYTE) + WORD_W'(FRAME_TYPE_BYTE)
                 + WORD_W'(pop_report.mask) + WORD_W'(FRAME_PAD_BYTE);
    end

    // Byte select
    always_comb
    begin
        case (idx_reg)
            FB_HEAD_LO: frame.frame_byte = rep_reg.head[7:0];
            FB_HEAD_HI: frame.frame_byte = rep_reg.head[15:8];
            FB_LEN:     frame.frame_byte = FRAME_LEN_BYTE;
            FB_CMD_LO:  frame.frame_byte = rep_reg.command[7:0];
            FB_CMD_HI:  frame.frame_byte = rep_reg.command[15:8];
            FB_PAD_A:   frame.frame_byte = FRAME_PAD_BYTE;
            FB_TYPE:    frame.frame_byte = FRAME_TYPE_BYTE;
            FB_MASK:    frame.frame_byte = rep_reg.mask;
            FB_PAD_B:   frame.frame_byte = FRAME_PAD_BYTE;
            FB_SUM_LO:  frame.frame_byte = sum_reg[7:0];
            FB_SUM_HI:  frame.frame_byte = sum_reg[15:8];
            default:    frame.frame_byte = FRAME_PAD_BYTE;
        endcase
    end

    assign frame.valid      = busy_reg;
    assign frame.frame_last = last_out;

    // Serialiser control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_fire)
        begin
            if (last_out)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Frame contents held for the whole frame
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rep_reg <= pop_report;
            sum_reg <= sum_next;
        end
    end

endmodule

/* rtl/core/vehicle_fault_watchdog_reporter_core.sv */
// Vehicle fault watchdog and reporter.
// tick:  one transaction per 100 ms tick carrying link status, four wheel
//        target/measured speeds and the gyro, accelerometer and magnetometer
//        triplets. Back-to-back ticks are accepted every cycle while the
//        report queue has room.
// cfg:   register writes (index, data), always ready; write only while idle.
//        Indexes 0..5: speed tolerance, stall ticks, comm ticks, report ticks,
//        frame header, command code. Other indexes are ignored.
// frame: an 11-byte fault report, one byte per transaction, frame_last on
//        the final byte. A report passes the queue and the serialiser
//        registers; a frame drains one byte per cycle while ready is high.
// The detectors are combinational, with state registered per accepted
// tick; reports wait in a small queue (QUEUE_DEPTH entries) in front of
// the byte serialiser. If the receiver stalls, bytes hold and reports
// collect in the queue; when it is full the tick channel deasserts ready.
// Reset clears all counters, the fault mask, the queue and the serialiser,
// and loads the register defaults.
module vehicle_fault_watchdog_reporter_core #(
    parameter int QUEUE_DEPTH = vfw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    vfw_tick_if.sink     tick,
    vfw_cfg_if.sink      cfg,
    vfw_frame_if.source  frame
);
    import vfw_pkg::*;

    logic        queue_full;
    logic        push;
    vfw_report_t push_report;
    logic        pop_valid;
    logic        pop;
    vfw_report_t pop_report;

    // Detectors and configuration
    vfw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .cfg         (cfg),
        .queue_full  (queue_full),
        .push        (push),
        .push_report (push_report)
    );

    // Pending reports
    vfw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_report (push_report),
        .full        (queue_full),
        .pop_valid   (pop_valid),
        .pop         (pop),
        .pop_report  (pop_report)
    );

    // Frame serialiser
    vfw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_report (pop_report),
        .frame      (frame)
    );

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vfw_pkg::*;

    // Indexes past the last register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 16;
    localparam int PRINT_LIMIT   = 100;

    // One 100 ms tick as seen by the detectors
    typedef struct {
        logic                      rx_ok;
        logic signed [SPEED_W-1:0] aim [NUM_WHEELS];
        logic signed [SPEED_W-1:0] now [NUM_WHEELS];
        logic [TRIPLET_W-1:0]      trip [NUM_SENSORS];
    } tick_t;

    // One expected byte of a fault report frame
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } frame_beat_t;

    logic clk;
    logic rst_n;

    vfw_tick_if  tick_ch ();
    vfw_cfg_if   cfg_ch ();
    vfw_frame_if frame_ch ();

    vehicle_fault_watchdog_reporter_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .cfg   (cfg_ch),
        .frame (frame_ch)
    );

    // Register copies
    logic [SPEED_W-1:0] tol_reg;
    logic [COUNT_W-1:0] stall_reg;
    logic [COUNT_W-1:0] comm_reg;
    logic [COUNT_W-1:0] report_reg;
    logic [WORD_W-1:0]  head_reg;
    logic [WORD_W-1:0]  cmd_reg;

    // Watchdog state
    logic [BYTE_W-1:0]    fault_bits;
    logic [COUNT_W-1:0]   link_age;
    logic [COUNT_W-1:0]   report_age;
    logic [COUNT_W-1:0]   wheel_lag [NUM_WHEELS];
    logic [COUNT_W-1:0]   sensor_still [NUM_SENSORS];
    logic [TRIPLET_W-1:0] last_trip [NUM_SENSORS];

    frame_beat_t pending_bytes [$];

    // Stimulus bookkeeping
    logic [TRIPLET_W-1:0] cur_trip [NUM_SENSORS];
    int unsigned          trip_stamp = 0;
    int                   items_sent = 0;
    int                   bytes_seen = 0;
    int                   rx_hold = 0;
    bit                   tx_burst = 1'b0;
    bit                   rx_burst = 1'b0;
    int                   err_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, what);
    endtask

    // Saturating count step
    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return c + {{(COUNT_W-1){1'b0}}, ~&c};
    endfunction

    function automatic void reset_watchdog();
        tol_reg    = SPEED_TOLERANCE_RST;
        stall_reg  = STALL_TICKS_RST;
        comm_reg   = COMM_TICKS_RST;
        report_reg = REPORT_TICKS_RST;
        head_reg   = FRAME_HEAD_RST;
        cmd_reg    = COMMAND_CODE_RST;
        fault_bits = '0;
        link_age   = '0;
        report_age = '0;
        foreach (wheel_lag[w])
            wheel_lag[w] = '0;
        foreach (sensor_still[s])
        begin
            sensor_still[s] = '0;
            last_trip[s]    = '0;
            cur_trip[s]     = '0;
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] val);
        case (idx)
            CFG_SPEED_TOLERANCE: tol_reg    = val;
            CFG_STALL_TICKS:     stall_reg  = val[COUNT_W-1:0];
            CFG_COMM_TICKS:      comm_reg   = val[COUNT_W-1:0];
            CFG_REPORT_TICKS:    report_reg = val[COUNT_W-1:0];
            CFG_FRAME_HEAD:      head_reg   = val;
            CFG_COMMAND_CODE:    cmd_reg    = val;
            default: ;
        endcase
    endfunction

    // Shared wheel/sensor rule: count while active, flag on release past stall
    function automatic void track(input bit active, input int pos,
                                  inout logic [COUNT_W-1:0] cnt);
        if (active)
            cnt = bump(cnt);
        else
        begin
            if (cnt > stall_reg)
                fault_bits[pos] = 1'b1;
            cnt = '0;
        end
    endfunction

    // Advance the watchdog by one tick and queue any report bytes
    function automatic void predict_tick(input tick_t t);
        int                d;
        logic [BYTE_W-1:0] b [FRAME_LEN];
        logic [WORD_W-1:0] sum;
        frame_beat_t       beat;

        report_age = bump(report_age);

        if (t.rx_ok)
            link_age = '0;
        else if (link_age > comm_reg)
            fault_bits[FAULT_LINK] = 1'b1;
        else
            link_age = bump(link_age);

        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            d = int'(t.aim[w]) - int'(t.now[w]);
            if (d < 0)
                d = -d;
            track(d > int'(tol_reg), FAULT_WHEEL_FIRST + w, wheel_lag[w]);
        end

        for (int s = 0; s < NUM_SENSORS; s++)
        begin
            track(t.trip[s] == last_trip[s], FAULT_SENSOR_FIRST + s, sensor_still[s]);
            last_trip[s] = t.trip[s];
        end

        if (fault_bits != '0 && report_age > report_reg)
        begin
            b[FB_HEAD_LO] = head_reg[7:0];
            b[FB_HEAD_HI] = head_reg[15:8];
            b[FB_LEN]     = FRAME_LEN_BYTE;
            b[FB_CMD_LO]  = cmd_reg[7:0];
            b[FB_CMD_HI]  = cmd_reg[15:8];
            b[FB_PAD_A]   = FRAME_PAD_BYTE;
            b[FB_TYPE]    = FRAME_TYPE_BYTE;
            b[FB_MASK]    = fault_bits;
            b[FB_PAD_B]   = FRAME_PAD_BYTE;
            sum = '0;
            for (int i = 0; i < FB_SUM_LO; i++)
                sum += b[i];
            b[FB_SUM_LO] = sum[7:0];
            b[FB_SUM_HI] = sum[15:8];
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                beat.value = b[i];
                beat.last  = (i == FRAME_LEN - 1);
                pending_bytes.push_back(beat);
            end
            report_age = '0;
            fault_bits = '0;
        end
    endfunction

    function automatic logic [TRIPLET_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TRIPLET_W-1:0];
    endfunction

    // Target/measured pair whose gap is past or within the tolerance
    function automatic void speed_pair(input bit lagging,
                                       output logic signed [SPEED_W-1:0] aim,
                                       output logic signed [SPEED_W-1:0] now);
        int m;
        int hi;
        int lo;
        hi = int'(tol_reg) + 64;
        if (hi > 65535)
            hi = 65535;
        if (lagging && tol_reg != 16'hFFFF)
            m = ($urandom_range(0, 3) == 0) ? $urandom_range(int'(tol_reg) + 1, 65535)
                                            : $urandom_range(int'(tol_reg) + 1, hi);
        else if (lagging)
            m = $urandom_range(0, 65535);
        else
            m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(tol_reg))
                                            : $urandom_range(0, (hi - 64 < 64) ? hi - 64 : 64);
        lo = int'($urandom_range(0, 65535 - m)) - 32768;
        if ($urandom_range(0, 1))
        begin
            aim = SPEED_W'(lo + m);
            now = SPEED_W'(lo);
        end
        else
        begin
            aim = SPEED_W'(lo);
            now = SPEED_W'(lo + m);
        end
    endfunction

    function automatic int run_len(input logic [COUNT_W-1:0] thr);
        return $urandom_range(0, (thr < 24) ? int'(thr) + 3 : 30);
    endfunction

    // Quiet tick: link fine, wheels on target, every triplet new
    function automatic tick_t fresh_tick();
        tick_t t;
        t.rx_ok = 1'b1;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            t.aim[w] = '0;
            t.now[w] = '0;
        end
        trip_stamp++;
        for (int s = 0; s < NUM_SENSORS; s++)
            t.trip[s] = {trip_stamp[15:0], 8'(s), 24'h5A5A5A};
        return t;
    endfunction

    // Send one tick transaction, first idling for a randomly drawn gap unless in burst mode
    task automatic send_tick(input tick_t t);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.rx_ok     <= t.rx_ok;
        tick_ch.aim_three <= t.aim[0];
        tick_ch.now_three <= t.now[0];
        tick_ch.aim_four  <= t.aim[1];
        tick_ch.now_four  <= t.now[1];
        tick_ch.aim_left  <= t.aim[2];
        tick_ch.now_left  <= t.now[2];
        tick_ch.aim_right <= t.aim[3];
        tick_ch.now_right <= t.now[3];
        tick_ch.gyro_xyz  <= t.trip[0];
        tick_ch.accel_xyz <= t.trip[1];
        tick_ch.mag_xyz   <= t.trip[2];
        tick_ch.valid     <= 1'b1;
        cur_trip = t.trip;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        predict_tick(t);
        items_sent++;
        if (items_sent % 20 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop sending, drain every expected byte and let the pipeline go quiet
    task automatic settle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [SPEED_W-1:0] tol,
                             input logic [COUNT_W-1:0] stall,
                             input logic [COUNT_W-1:0] comm,
                             input logic [COUNT_W-1:0] report,
                             input logic [WORD_W-1:0]  head,
                             input logic [WORD_W-1:0]  cmd);
        settle();
        write_reg(CFG_SPEED_TOLERANCE, tol);
        write_reg(CFG_STALL_TICKS, 16'(stall));
        write_reg(CFG_COMM_TICKS, 16'(comm));
        write_reg(CFG_REPORT_TICKS, 16'(report));
        write_reg(CFG_FRAME_HEAD, head);
        write_reg(CFG_COMMAND_CODE, cmd);
    endtask

    // Mostly well-formed fault runs with random content, some pure noise
    task automatic random_ticks(input int n);
        tick_t t;
        int    link_run;
        int    lag_run [NUM_WHEELS];
        int    hold_run [NUM_SENSORS];
        link_run = 0;
        lag_run  = '{default: 0};
        hold_run = '{default: 0};
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                t.rx_ok = 1'($urandom);
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    t.aim[w] = 16'($urandom);
                    t.now[w] = 16'($urandom);
                end
                for (int s = 0; s < NUM_SENSORS; s++)
                    t.trip[s] = $urandom_range(0, 1) ? cur_trip[s] : rand48();
            end
            else
            begin
                if (link_run > 0)
                begin
                    t.rx_ok = 1'b0;
                    link_run--;
                end
                else
                begin
                    t.rx_ok = 1'b1;
                    if ($urandom_range(0, 2) == 0)
                        link_run = run_len(comm_reg);
                end
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    speed_pair(lag_run[w] > 0, t.aim[w], t.now[w]);
                    if (lag_run[w] > 0)
                        lag_run[w]--;
                    else if ($urandom_range(0, 2) == 0)
                        lag_run[w] = run_len(stall_reg);
                end
                for (int s = 0; s < NUM_SENSORS; s++)
                begin
                    if (hold_run[s] > 0)
                    begin
                        t.trip[s] = cur_trip[s];
                        hold_run[s]--;
                    end
                    else
                    begin
                        t.trip[s] = rand48();
                        if ($urandom_range(0, 2) == 0)
                            hold_run[s] = run_len(stall_reg);
                    end
                end
            end
            send_tick(t);
        end
    endtask

    // Reset values: link fault after three silent ticks, report on the eleventh
    task automatic test_reset_defaults();
        tick_t t;
        for (int i = 0; i < 11; i++)
        begin
            t = fresh_tick();
            t.rx_ok  = 1'b0;
            t.aim[0] = 16'sd100;
            t.now[0] = 16'sd80;
            t.aim[1] = -16'sd5;
            t.now[1] = 16'sd16;
            send_tick(t);
        end
    endtask

    // Zero thresholds, full-scale words, speed extremes, sensor counter split
    task automatic test_directed_edges();
        tick_t t;
        configure(16'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_SPARE_LO, 16'h00FF);
        write_reg(CFG_SPARE_HI, 16'h00FF);

        t = fresh_tick();
        t.aim[0]  = 16'sh7FFF;
        t.now[0]  = 16'sh8000;
        t.aim[1]  = 16'sh8000;
        t.now[1]  = 16'sh7FFF;
        t.aim[3]  = 16'sd1;
        t.trip[0] = '1;
        t.trip[1] = '0;
        t.trip[2] = 48'h8000_0000_0001;
        send_tick(t);

        // lags end, gyro and accel frozen, link drops
        t = fresh_tick();
        t.rx_ok   = 1'b0;
        t.trip[0] = cur_trip[0];
        t.trip[1] = cur_trip[1];
        send_tick(t);

        // gyro releases; magnetometer moves while accel stays frozen
        t = fresh_tick();
        t.rx_ok   = 1'b0;
        t.trip[1] = cur_trip[1];
        send_tick(t);

        t = fresh_tick();
        t.trip[1] = cur_trip[1];
        send_tick(t);

        t = fresh_tick();
        send_tick(t);

        t = fresh_tick();
        t.aim[2] = 16'sh8000;
        t.now[2] = 16'sh8000;
        t.aim[3] = 16'sh7FFF;
        t.now[3] = 16'sh7FFF;
        send_tick(t);
    endtask

    // Several register settings with random traffic
    task automatic test_random_sweep();
        configure(16'($urandom_range(0, 300)), 8'd2, 8'd1, 8'd0,
                  16'($urandom), 16'($urandom));
        random_ticks(25);
        configure(16'($urandom_range(0, 300)), 8'd4, 8'd3, 8'd5,
                  16'($urandom), 16'($urandom));
        random_ticks(25);
        configure(16'd0, 8'd0, 8'd0, 8'd3, 16'($urandom), 16'($urandom));
        random_ticks(25);
        configure(16'hFFFF, 8'd1, 8'hFF, 8'd0, 16'($urandom), 16'($urandom));
        random_ticks(20);
        configure(16'($urandom), 8'd3, 8'd0, 8'hFF, 16'($urandom), 16'($urandom));
        random_ticks(15);
        configure(16'($urandom_range(0, 300)), 8'd6, 8'd2, 8'd1,
                  16'($urandom), 16'($urandom));
        random_ticks(30);
    endtask

    // Drive every counter into saturation with thresholds at the top,
    // then drop the thresholds by one so the held counts must fire
    task automatic test_counter_saturation();
        tick_t                t;
        logic [TRIPLET_W-1:0] held [NUM_SENSORS];
        configure(16'd100, 8'hFF, 8'hFF, 8'hFF, 16'($urandom), 16'($urandom));
        foreach (held[s])
            held[s] = rand48();

        for (int i = 0; i < 259; i++)
        begin
            t.rx_ok = 1'b0;
            for (int w = 0; w < NUM_WHEELS; w++)
                speed_pair(!(i == 258 && w == 0), t.aim[w], t.now[w]);
            t.trip    = held;
            if (i == 258)
                t.trip[0] = rand48();
            send_tick(t);
        end

        settle();
        write_reg(CFG_STALL_TICKS, 16'd254);
        write_reg(CFG_COMM_TICKS, 16'd254);
        write_reg(CFG_REPORT_TICKS, 16'd254);

        t = fresh_tick();
        t.rx_ok = 1'b0;
        send_tick(t);
    endtask

    // Receiver back-pressure, drawn afresh after every byte
    initial
    begin
        frame_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                frame_ch.ready <= 1'b0;
                rx_hold--;
            end
            else
                frame_ch.ready <= 1'b1;
        end
    end

    // Compare each frame byte with the oldest expectation
    always @(posedge clk)
    begin : frame_check
        frame_beat_t want;
        if (rst_n && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("frame byte %02h with none expected",
                                          frame_ch.frame_byte));
            else
            begin
                want = pending_bytes.pop_front();
                if (frame_ch.frame_byte !== want.value)
                    report_mismatch($sformatf("frame_byte got %02h want %02h",
                                              frame_ch.frame_byte, want.value));
                if (frame_ch.frame_last !== want.last)
                    report_mismatch($sformatf("frame_last got %b want %b",
                                              frame_ch.frame_last, want.last));
            end
            bytes_seen++;
            if (bytes_seen % 32 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
            rx_hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        tick_ch.valid      = 1'b0;
        tick_ch.rx_ok      = 1'b0;
        tick_ch.aim_three  = '0;
        tick_ch.now_three  = '0;
        tick_ch.aim_four   = '0;
        tick_ch.now_four   = '0;
        tick_ch.aim_left   = '0;
        tick_ch.now_left   = '0;
        tick_ch.aim_right  = '0;
        tick_ch.now_right  = '0;
        tick_ch.gyro_xyz   = '0;
        tick_ch.accel_xyz  = '0;
        tick_ch.mag_xyz    = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        reset_watchdog();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_edges();
        test_random_sweep();
        test_counter_saturation();

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
